@@ hw/rtl/spq_pkg.sv @@
// Package: types, constants and pointer helpers of the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int PTR_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 16;
    localparam int COUNT_W  = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_INS_PUT,
        S_DEL_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] item_in;
        logic [DATA_W-1:0] prio_in;
    } t_cmd_in;

    typedef struct packed {
        logic [DATA_W-1:0]  item_out;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } t_result;

    typedef struct packed {
        logic [DATA_W-1:0] item;
        logic [DATA_W-1:0] prio;
    } t_entry;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
    endfunction

endpackage

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level: sorted priority queue in a circular entry memory with a shift sequencer.
//
//  channel   direction  handshake                   payload
//  command   in         start high, busy low        i_cmd_in  (cmd, item_in, prio_in)
//  result    out        o_done strobe, one cycle    o_result  (item_out, status, count)
//
// Entries sit in a circular memory from a head pointer, highest priority first.
// Insert walks from the tail through the single memory read port and comparator,
// moving each entry of lower or equal priority down one place, until an entry of
// higher priority ends the walk or none is left; the new entry fills the gap.
// Delete reads the head entry; clear, a full insert, an empty delete or an unknown
// command finish in idle; the result strobe comes in the cycle after the last step.
// Synchronous reset empties the queue; the memory needs no clearing.
// The result cannot be held off, so it never stalls.
`timescale 1ns / 1ps
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd_in i_cmd_in,
    output logic    o_done,
    output t_result o_result
);

    t_entry             r_mem [CAPACITY];
    t_entry             r_rd_data;
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_tail, n_tail;
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    t_cmd_in            r_cmd, n_cmd;
    logic               r_done, n_done;
    t_result            r_result, n_result;

    logic [PTR_W-1:0]   w_rd_addr;
    logic               w_we;
    logic [PTR_W-1:0]   w_wr_addr;
    t_entry             w_wr_data;
    logic               w_shift;
    logic               w_accept;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_shift  = (r_rd_data.prio <= r_cmd.prio_in);
    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_cmd_in.cmd)
                        CMD_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_state = S_IDLE;
                            end else if (r_count == '0) begin
                                n_state = S_INS_PUT;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        CMD_DELETE: begin
                            n_state = (r_count == '0) ? S_IDLE : S_DEL_OUT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_INS_RD:  n_state = S_INS_CMP;
            S_INS_CMP: begin
                if (w_shift && (r_k != CNT_W'(1))) begin
                    n_state = S_INS_RD;
                end else begin
                    n_state = S_INS_PUT;
                end
            end
            S_INS_PUT: n_state = S_IDLE;
            S_DEL_OUT: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_k       = r_k;
        n_head    = r_head;
        n_tail    = r_tail;
        n_wr_ptr  = r_wr_ptr;
        n_cmd     = r_cmd;
        n_done    = 1'b0;
        n_result  = r_result;
        w_rd_addr = r_head;
        w_we      = 1'b0;
        w_wr_addr = r_wr_ptr;
        w_wr_data = r_rd_data;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd             = i_cmd_in;
                    n_result.item_out = '0;
                    n_result.status   = ST_OK;
                    n_result.count    = COUNT_W'(r_count);
                    case (i_cmd_in.cmd)
                        CMD_INSERT: begin
                            n_k      = r_count;
                            n_wr_ptr = r_tail;
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_result.status = ST_FULL;
                                n_done          = 1'b1;
                            end
                        end
                        CMD_DELETE: begin
                            if (r_count == '0) begin
                                n_result.status = ST_EMPTY;
                                n_done          = 1'b1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_count        = '0;
                            n_tail         = r_head;
                            n_result.count = '0;
                            n_done         = 1'b1;
                        end
                        default: n_done = 1'b1;
                    endcase
                end
            end
            S_INS_RD: begin
                w_rd_addr = ptr_dec(r_wr_ptr);
            end
            S_INS_CMP: begin
                if (w_shift) begin
                    w_we      = 1'b1;
                    w_wr_data = r_rd_data;
                    n_wr_ptr  = ptr_dec(r_wr_ptr);
                    n_k       = r_k - 1'b1;
                end
            end
            S_INS_PUT: begin
                w_we              = 1'b1;
                w_wr_data.item    = r_cmd.item_in;
                w_wr_data.prio    = r_cmd.prio_in;
                n_count           = r_count + 1'b1;
                n_tail            = ptr_inc(r_tail);
                n_result.item_out = '0;
                n_result.status   = ST_OK;
                n_result.count    = COUNT_W'(r_count + 1'b1);
                n_done            = 1'b1;
            end
            S_DEL_OUT: begin
                n_head            = ptr_inc(r_head);
                n_count           = r_count - 1'b1;
                n_result.item_out = r_rd_data.item;
                n_result.status   = ST_OK;
                n_result.count    = COUNT_W'(r_count - 1'b1);
                n_done            = 1'b1;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_wr_ptr <= n_wr_ptr;
        r_cmd    <= n_cmd;
        r_result <= n_result;
    end

endmodule
